// ===== rtl/core/mspc_pkg.sv =====
// ----------------------------------------------------------------------------
// mspc_pkg
// Shared types, opcodes and result codes of the MIPS subset core.
// ----------------------------------------------------------------------------
`default_nettype none

package mspc_pkg;

    localparam int NUM_REGS = 32;
    localparam int RIDX_W   = 5;
    localparam int XLEN     = 32;
    localparam int OFF_W    = 16;
    localparam int MADDR_W  = 10;

    typedef logic [XLEN-1:0]   word_t;
    typedef logic [RIDX_W-1:0] ridx_t;
    typedef logic [OFF_W-1:0]  off_t;
    typedef logic [2:0]        op_kind_t;

    // Primary opcodes, bits 31..26, with the add funct (bits 5..0) and beqz rt code (bits 20..16).
    localparam logic [5:0] OPC_LOAD    = 6'b100000;
    localparam logic [5:0] OPC_STORE   = 6'b101000;
    localparam logic [5:0] OPC_SPECIAL = 6'b000000;
    localparam logic [5:0] OPC_REGIMM  = 6'b000001;
    localparam logic [5:0] FUNCT_ADD   = 6'b100000;
    localparam ridx_t      SUB_BEQZ    = 5'b00010;

    localparam word_t PC_STEP = 32'd4;

    // Result codes reported in op_kind.
    localparam op_kind_t KIND_NOP   = 3'd0;
    localparam op_kind_t KIND_LOAD  = 3'd1;
    localparam op_kind_t KIND_STORE = 3'd2;
    localparam op_kind_t KIND_ADD   = 3'd3;
    localparam op_kind_t KIND_BEQZ  = 3'd4;
    localparam op_kind_t KIND_BAD   = 3'd5;

    // Register indices; registers one and two have a nonzero value after reset.
    localparam ridx_t REG_ZERO = 5'd0;
    localparam ridx_t REG_ONE  = 5'd1;
    localparam ridx_t REG_TWO  = 5'd2;

    typedef struct packed {
        op_kind_t kind;
        ridx_t    rs;
        ridx_t    rt;
        ridx_t    rd;
        off_t     off;
    } dec_t;

    typedef struct packed {
        logic  en;
        ridx_t idx;
        word_t data;
    } rf_wr_t;

    function automatic word_t rf_reset_value(input ridx_t idx);
        word_t val;
        val = '0;
        if (idx == REG_ONE) begin
            val = 32'd1;
        end
        else if (idx == REG_TWO) begin
            val = 32'd2;
        end
        return val;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/mspc_instr_if.sv =====
// ----------------------------------------------------------------------------
// mspc_instr_if
// Instruction channel: one instruction word per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mspc_instr_if;
    logic        valid;
    logic        ready;
    logic [31:0] instr_word;

    modport source (output valid, output instr_word, input ready);
    modport sink   (input valid, input instr_word, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mspc_result_if.sv =====
// ----------------------------------------------------------------------------
// mspc_result_if
// Result channel: one execution report per transaction.
// ----------------------------------------------------------------------------
`default_nettype none

interface mspc_result_if;
    logic               valid;
    logic               ready;
    logic [2:0]         op_kind;
    logic [31:0]        next_pc;
    logic               branch_taken;
    logic               reg_write;
    logic [4:0]         reg_index;
    logic signed [31:0] reg_value;
    logic               mem_write;
    logic [9:0]         mem_addr;
    logic signed [31:0] mem_data;

    modport source (
        output valid, output op_kind, output next_pc, output branch_taken,
        output reg_write, output reg_index, output reg_value,
        output mem_write, output mem_addr, output mem_data,
        input  ready
    );
    modport sink (
        input  valid, input op_kind, input next_pc, input branch_taken,
        input  reg_write, input reg_index, input reg_value,
        input  mem_write, input mem_addr, input mem_data,
        output ready
    );
endinterface

`default_nettype wire

// ===== rtl/core/mspc_decode.sv =====
// ----------------------------------------------------------------------------
// mspc_decode
// Splits an instruction word into its fields and classifies it.
// ----------------------------------------------------------------------------
`default_nettype none

module mspc_decode
    import mspc_pkg::*;
(
    input  word_t instr_word,
    output dec_t  dec
);

    logic [5:0] opc;
    logic [5:0] funct;

    assign opc   = instr_word[31:26];
    assign funct = instr_word[5:0];

    always_comb
    begin
        dec.rs  = instr_word[25:21];
        dec.rt  = instr_word[20:16];
        dec.rd  = instr_word[15:11];
        dec.off = instr_word[15:0];
        priority if (instr_word == '0)
        begin
            dec.kind = KIND_NOP;
        end
        else if (opc == OPC_LOAD)
        begin
            dec.kind = KIND_LOAD;
        end
        else if (opc == OPC_STORE)
        begin
            dec.kind = KIND_STORE;
        end
        else if (opc == OPC_SPECIAL && funct == FUNCT_ADD)
        begin
            dec.kind = KIND_ADD;
        end
        else if (opc == OPC_REGIMM && instr_word[20:16] == SUB_BEQZ)
        begin
            dec.kind = KIND_BEQZ;
        end
        else
        begin
            dec.kind = KIND_BAD;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mspc_regfile.sv =====
// ----------------------------------------------------------------------------
// mspc_regfile
// Register bank: two registered read ports, one write port, reset values
// supplied through per-register valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module mspc_regfile
    import mspc_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   rd_en,
    input  ridx_t  rs_idx,
    input  ridx_t  rt_idx,
    input  rf_wr_t wr,
    output word_t  rs_data,
    output word_t  rt_data
);

    word_t                mem [NUM_REGS];
    word_t                rs_mem_reg;
    word_t                rt_mem_reg;
    ridx_t                rs_idx_reg;
    ridx_t                rt_idx_reg;
    logic                 rs_vld_reg;
    logic                 rt_vld_reg;
    logic [NUM_REGS-1:0]  vld_reg;
    rf_wr_t               byp_reg;

    // Read-first: a write at the same edge as a read is covered by byp_reg.
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rs_mem_reg <= mem[rs_idx];
            rt_mem_reg <= mem[rt_idx];
            rs_idx_reg <= rs_idx;
            rt_idx_reg <= rt_idx;
            rs_vld_reg <= vld_reg[rs_idx];
            rt_vld_reg <= vld_reg[rt_idx];
        end
        if (wr.en)
        begin
            mem[wr.idx] <= wr.data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
            byp_reg <= '0;
        end
        else
        begin
            if (wr.en)
            begin
                vld_reg[wr.idx] <= 1'b1;
                byp_reg         <= wr;
            end
        end
    end

    // The bypass holds the most recent write, so it always agrees with the
    // bank and may be applied no matter how long ago the read took place.
    function automatic word_t pick(input ridx_t idx, input logic vld, input word_t raw,
                                   input rf_wr_t byp);
        word_t val;
        val = vld ? raw : rf_reset_value(idx);
        if (byp.en && byp.idx == idx)
        begin
            val = byp.data;
        end
        return val;
    endfunction

    assign rs_data = pick(rs_idx_reg, rs_vld_reg, rs_mem_reg, byp_reg);
    assign rt_data = pick(rt_idx_reg, rt_vld_reg, rt_mem_reg, byp_reg);

endmodule

`default_nettype wire

// ===== rtl/core/mspc_datamem.sv =====
// ----------------------------------------------------------------------------
// mspc_datamem
// Word-addressed data memory, single port, registered read, with a clearing
// pass after reset.
// ----------------------------------------------------------------------------
`default_nettype none

module mspc_datamem
    import mspc_pkg::*;
#(
    parameter int MEM_WORDS = 1024,
    localparam int AW = $clog2(MEM_WORDS)
)
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          rd_en,
    input  logic          wr_en,
    input  logic [AW-1:0] addr,
    input  word_t         wdata,
    output word_t         rdata,
    output logic          busy
);

    word_t          mem [MEM_WORDS];
    word_t          rdata_reg;
    logic [AW-1:0]  clr_addr_reg;
    logic           busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg     <= 1'b1;
            clr_addr_reg <= '0;
        end
        else if (busy_reg)
        begin
            if (clr_addr_reg == AW'(MEM_WORDS - 1))
            begin
                busy_reg <= 1'b0;
            end
            clr_addr_reg <= clr_addr_reg + 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (busy_reg)
        begin
            mem[clr_addr_reg] <= '0;
        end
        else if (wr_en)
        begin
            mem[addr] <= wdata;
        end
        if (rd_en)
        begin
            rdata_reg <= mem[addr];
        end
    end

    assign rdata = rdata_reg;
    assign busy  = busy_reg;

endmodule

`default_nettype wire

// ===== rtl/core/mips_subset_core.sv =====
// ----------------------------------------------------------------------------
// mips_subset_core
// Executes lw, sw, add, beqz and nop against a register bank and a data
// memory and reports one result per instruction, other words as bad. The
// core accepts one instruction per clock cycle unless the result channel
// stalls: the register bank read is registered, then the add, address or
// branch logic and the data memory access run as the instruction moves into
// the output stage, where the result sits until taken. Results of earlier
// instructions, including load data, are forwarded, so there is no interlock
// and no bubble. After reset the data memory is cleared one word a cycle,
// which keeps the instruction channel not ready until every word is cleared.
// MEM_WORDS is to be a power of two, not enforced here; addresses wrap to it.
// ----------------------------------------------------------------------------
`default_nettype none

module mips_subset_core
    import mspc_pkg::*;
#(
    parameter int MEM_WORDS = 1024
)
(
    input  logic          clk,
    input  logic          rst_n,
    mspc_instr_if.sink    instr,
    mspc_result_if.source result
);

    localparam int AW = $clog2(MEM_WORDS);

    dec_t           in_dec;
    dec_t           s1_dec_reg;
    logic           s1_valid_reg;

    logic           s2_valid_reg;
    op_kind_t       s2_kind_reg;
    word_t          s2_npc_reg;
    logic           s2_taken_reg;
    logic           s2_wr_en_reg;
    ridx_t          s2_wr_idx_reg;
    word_t          s2_val_reg;
    logic [AW-1:0]  s2_addr_reg;

    word_t          pc_reg;
    word_t          pc_next;

    logic           s2_en;
    logic           s1_free;
    logic           accept;
    logic           s1_move;

    word_t          rs_rf;
    word_t          rt_rf;
    word_t          rs_val;
    word_t          rt_val;
    word_t          s2_fwd_data;
    logic           s2_fwd;
    word_t          ea;
    word_t          add_sum;
    logic           s1_taken;
    logic           s1_wr_en;
    ridx_t          s1_wr_idx;
    word_t          s1_val;
    logic [AW-1:0]  s1_addr;

    rf_wr_t         rf_wr;
    word_t          mem_rdata;
    logic           mem_busy;
    logic           mem_rd_en;
    logic           mem_wr_en;

    // ------------------------------------------------------------------
    // Handshake control
    // ------------------------------------------------------------------
    assign s2_en       = !s2_valid_reg || result.ready;
    assign s1_free     = !s1_valid_reg || s2_en;
    assign instr.ready = s1_free && !mem_busy;
    assign accept      = instr.valid && instr.ready;
    assign s1_move     = s2_en && s1_valid_reg;

    mspc_decode u_decode (
        .instr_word (instr.instr_word),
        .dec        (in_dec)
    );

    mspc_regfile u_regfile (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (accept),
        .rs_idx  (in_dec.rs),
        .rt_idx  (in_dec.rt),
        .wr      (rf_wr),
        .rs_data (rs_rf),
        .rt_data (rt_rf)
    );

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_dec_reg <= in_dec;
        end
    end

    // ------------------------------------------------------------------
    // Execute: operands forwarded from the output stage when it holds a
    // register write that the bank has not yet seen.
    // ------------------------------------------------------------------
    assign s2_fwd_data = (s2_kind_reg == KIND_LOAD) ? mem_rdata : s2_val_reg;
    assign s2_fwd      = s2_valid_reg && s2_wr_en_reg;

    assign rs_val = (s2_fwd && s2_wr_idx_reg == s1_dec_reg.rs) ? s2_fwd_data : rs_rf;
    assign rt_val = (s2_fwd && s2_wr_idx_reg == s1_dec_reg.rt) ? s2_fwd_data : rt_rf;

    assign ea       = rs_val + {16'b0, s1_dec_reg.off};
    assign s1_addr  = ea[AW-1:0];
    assign add_sum  = rs_val + rt_val;
    assign s1_taken = (s1_dec_reg.kind == KIND_BEQZ) && (rs_val == '0);
    assign pc_next  = s1_taken ? (pc_reg + {16'b0, s1_dec_reg.off}) : (pc_reg + PC_STEP);

    always_comb
    begin
        s1_wr_en  = 1'b0;
        s1_wr_idx = REG_ZERO;
        s1_val    = '0;
        unique case (s1_dec_reg.kind)
            KIND_LOAD:
            begin
                s1_wr_en  = (s1_dec_reg.rt != REG_ZERO);
                s1_wr_idx = s1_wr_en ? s1_dec_reg.rt : REG_ZERO;
            end
            KIND_STORE:
            begin
                s1_val = rt_val;
            end
            KIND_ADD:
            begin
                s1_wr_en  = (s1_dec_reg.rd != REG_ZERO);
                s1_wr_idx = s1_wr_en ? s1_dec_reg.rd : REG_ZERO;
                s1_val    = add_sum;
            end
            default:
            begin
                s1_wr_en = 1'b0;
            end
        endcase
    end

    assign mem_rd_en = s1_move && (s1_dec_reg.kind == KIND_LOAD);
    assign mem_wr_en = s1_move && (s1_dec_reg.kind == KIND_STORE);

    mspc_datamem #(
        .MEM_WORDS (MEM_WORDS)
    ) u_datamem (
        .clk   (clk),
        .rst_n (rst_n),
        .rd_en (mem_rd_en),
        .wr_en (mem_wr_en),
        .addr  (s1_addr),
        .wdata (rt_val),
        .rdata (mem_rdata),
        .busy  (mem_busy)
    );

    // ------------------------------------------------------------------
    // Pipeline control registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            pc_reg       <= '0;
        end
        else
        begin
            if (s1_free)
            begin
                s1_valid_reg <= accept;
            end
            if (s2_en)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (s1_move)
            begin
                pc_reg <= pc_next;
            end
        end
    end

    // Output stage payload.
    always_ff @(posedge clk)
    begin
        if (s1_move)
        begin
            s2_kind_reg   <= s1_dec_reg.kind;
            s2_npc_reg    <= pc_next;
            s2_taken_reg  <= s1_taken;
            s2_wr_en_reg  <= s1_wr_en;
            s2_wr_idx_reg <= s1_wr_idx;
            s2_val_reg    <= s1_val;
            s2_addr_reg   <= (s1_dec_reg.kind == KIND_LOAD || s1_dec_reg.kind == KIND_STORE)
                             ? s1_addr : '0;
        end
    end

    // The bank is written when the result transaction completes.
    assign rf_wr.en   = s2_valid_reg && result.ready && s2_wr_en_reg;
    assign rf_wr.idx  = s2_wr_idx_reg;
    assign rf_wr.data = s2_fwd_data;

    // ------------------------------------------------------------------
    // Result channel
    // ------------------------------------------------------------------
    assign result.valid        = s2_valid_reg;
    assign result.op_kind      = s2_kind_reg;
    assign result.next_pc      = s2_npc_reg;
    assign result.branch_taken = s2_taken_reg;
    assign result.reg_write    = s2_wr_en_reg;
    assign result.reg_index    = s2_wr_idx_reg;
    assign result.reg_value    = $signed(s2_wr_en_reg ? s2_fwd_data : 32'd0);
    assign result.mem_write    = (s2_kind_reg == KIND_STORE);
    assign result.mem_addr     = MADDR_W'(s2_addr_reg);

    always_comb
    begin
        unique case (s2_kind_reg)
            KIND_LOAD:  result.mem_data = $signed(mem_rdata);
            KIND_STORE: result.mem_data = $signed(s2_val_reg);
            default:    result.mem_data = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_no_r0_write: assert property (@(posedge clk) disable iff (!rst_n)
        rf_wr.en |-> rf_wr.idx != REG_ZERO)
        else $error("register zero written");

    a_pc_step: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_move && s1_dec_reg.kind != KIND_BEQZ) |=> pc_reg == $past(pc_reg) + PC_STEP)
        else $error("program counter did not advance by one word");

    a_store_no_reg: assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.mem_write) |-> !result.reg_write)
        else $error("store reported a register write");

    a_no_issue_clear: assert property (@(posedge clk) disable iff (!rst_n)
        mem_busy |-> !s1_valid_reg && !s2_valid_reg)
        else $error("instruction in flight during memory clearing");

endmodule

`default_nettype wire
